// ----- src/fqvp_pkg.sv -----
// Shared types and constants for the FIFO queue with value purge.
package fqvp_pkg;

  // Default number of entries in the queue
  localparam int unsigned Depth = 128;

  // Payload widths fixed by the interface
  localparam int unsigned WordW   = 32;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 8;

  // Operation codes carried by a request
  typedef enum logic [OpW-1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_PURGE = 2'd2
  } op_e;

  // Status codes carried by a response
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Word returned by a dequeue from an empty queue
  localparam logic [WordW-1:0] EmptyWord = '1;

  // Per-cycle control broadcast along the chain of cells
  typedef struct packed {
    logic             shift;  // every cell not being written takes its upper neighbour's word
    logic             write;  // the selected cell loads data
    logic [WordW-1:0] data;
  } chain_ctl_t;

endpackage

// ----- src/fqvp_if.sv -----
// Request and response channel interfaces of the FIFO queue with value purge.
interface fqvp_req_if;
  logic                         valid;
  logic                         ready;
  logic [fqvp_pkg::OpW-1:0]     op;
  logic signed [fqvp_pkg::WordW-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface fqvp_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [fqvp_pkg::StatusW-1:0]     status;
  logic signed [fqvp_pkg::WordW-1:0] data;
  logic [fqvp_pkg::CountW-1:0]      removed;
  logic [fqvp_pkg::CountW-1:0]      fill;

  modport source (output valid, output status, output data, output removed, output fill,
                  input ready);
  modport sink   (input valid, input status, input data, input removed, input fill,
                  output ready);
endinterface

// ----- src/fqvp_cell.sv -----
// One storage cell of the queue chain: holds a word, loads or shifts it.
module fqvp_cell (
  input  logic                           clk_i,
  input  fqvp_pkg::chain_ctl_t           ctl_i,
  input  logic                           sel_i,
  input  logic [fqvp_pkg::WordW-1:0]     nb_i,
  output logic [fqvp_pkg::WordW-1:0]     word_o
);

  logic [fqvp_pkg::WordW-1:0] word_q;

  // Load on a directed write, else take the neighbour's word on a shift
  always_ff @(posedge clk_i) begin
    if (ctl_i.write && sel_i) begin
      word_q <= ctl_i.data;
    end else if (ctl_i.shift) begin
      word_q <= nb_i;
    end
  end

  assign word_o = word_q;

endmodule

// ----- src/fqvp_chain.sv -----
// Row of queue cells; cell 0 holds the oldest entry.
module fqvp_chain #(
  parameter int unsigned DEPTH = fqvp_pkg::Depth,
  localparam int unsigned IdxW = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  fqvp_pkg::chain_ctl_t        ctl_i,
  input  logic [IdxW-1:0]             wr_idx_i,
  output logic [fqvp_pkg::WordW-1:0]  head_o
);

  logic [fqvp_pkg::WordW-1:0] word [DEPTH];

  // Build the chain; each cell sees the word of the cell above it, the top cell sees zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [fqvp_pkg::WordW-1:0] nb;
    logic                       sel;

    if (i == DEPTH - 1) begin : g_top
      assign nb = '0;
    end else begin : g_mid
      assign nb = word[i+1];
    end

    assign sel = (wr_idx_i == IdxW'(i));

    fqvp_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl_i),
      .sel_i  (sel),
      .nb_i   (nb),
      .word_o (word[i])
    );
  end

  assign head_o = word[0];

endmodule

// ----- src/fifo_queue_with_value_purge.sv -----
// Top level of the FIFO queue with value purge.
//
// A request carries op and value on the req channel; every request yields
// exactly one response (status, data, removed, fill) on the rsp channel.
// Both channels use valid/ready; a request is taken when both are high.
// Entries sit in a row of cells, the oldest in cell 0.
// Enqueue and dequeue complete in the cycle they are taken: the response
// is registered and visible in the next cycle, so these run at one request
// per cycle while the receiver keeps up.
// A purge walks the stored entries one per cycle: each cycle the head word
// leaves cell 0 and, unless it matches, is written back at the tail.
// No request is taken during the walk.
// A new request is taken while the response register is empty or is being
// drained in the same cycle; a stalled receiver therefore holds off input.
// Reset empties the queue and the response register; the cell contents are
// not cleared and are never read before being written.
module fifo_queue_with_value_purge #(
  parameter int unsigned DEPTH = fqvp_pkg::Depth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  fqvp_req_if.sink         req,
  fqvp_rsp_if.source       rsp
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  typedef enum logic {StIdle, StWalk} state_e;

  state_e                       state_q;
  logic [CntW-1:0]              count_q;
  logic [CntW-1:0]              steps_q;
  logic [CntW-1:0]              orig_q;
  logic [fqvp_pkg::WordW-1:0]   val_q;
  logic                         rsp_valid_q;
  logic [fqvp_pkg::StatusW-1:0] rsp_status_q;
  logic [fqvp_pkg::WordW-1:0]   rsp_data_q;
  logic [fqvp_pkg::CountW-1:0]  rsp_removed_q;
  logic [fqvp_pkg::CountW-1:0]  rsp_fill_q;

  fqvp_pkg::chain_ctl_t         ctl;
  logic [IdxW-1:0]              wr_idx;
  logic [fqvp_pkg::WordW-1:0]   head;
  logic                         acc;
  logic                         keep;
  logic [CntW-1:0]              count_m1;

  assign req.ready = (state_q == StIdle) && (!rsp_valid_q || rsp.ready);
  assign acc       = req.valid && req.ready;
  assign keep      = (head != val_q);
  assign count_m1  = count_q - CntW'(1);

  // Drive the chain for enqueue, dequeue and purge walk steps
  always_comb begin
    ctl       = '0;
    wr_idx    = count_q[IdxW-1:0];
    ctl.data  = req.value;
    unique case (state_q)
      StIdle: begin
        if (acc && req.op == fqvp_pkg::OP_ENQ && count_q < DepthCnt) begin
          ctl.write = 1'b1;
        end
        if (acc && req.op == fqvp_pkg::OP_DEQ && count_q != '0) begin
          ctl.shift = 1'b1;
        end
      end
      StWalk: begin
        if (steps_q != '0) begin
          ctl.shift = 1'b1;
          ctl.write = keep;
          ctl.data  = head;
          wr_idx    = count_m1[IdxW-1:0];
        end
      end
      default: ;
    endcase
  end

  fqvp_chain #(.DEPTH(DEPTH)) u_chain (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .wr_idx_i (wr_idx),
    .head_o   (head)
  );

  // Hold state, fill level and the response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      count_q       <= '0;
      steps_q       <= '0;
      orig_q        <= '0;
      rsp_valid_q   <= 1'b0;
      val_q         <= '0;
      rsp_status_q  <= fqvp_pkg::ST_OK;
      rsp_data_q    <= '0;
      rsp_removed_q <= '0;
      rsp_fill_q    <= '0;
    end else begin
      if (rsp_valid_q && rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (acc) begin
            rsp_status_q  <= fqvp_pkg::ST_OK;
            rsp_data_q    <= '0;
            rsp_removed_q <= '0;
            rsp_fill_q    <= fqvp_pkg::CountW'(count_q);
            rsp_valid_q   <= 1'b1;
            priority if (req.op == fqvp_pkg::OP_ENQ) begin
              if (count_q < DepthCnt) begin
                count_q    <= count_q + CntW'(1);
                rsp_fill_q <= fqvp_pkg::CountW'(count_q + CntW'(1));
              end else begin
                rsp_status_q <= fqvp_pkg::ST_FULL;
              end
            end else if (req.op == fqvp_pkg::OP_DEQ) begin
              if (count_q != '0) begin
                count_q    <= count_m1;
                rsp_data_q <= head;
                rsp_fill_q <= fqvp_pkg::CountW'(count_m1);
              end else begin
                rsp_status_q <= fqvp_pkg::ST_EMPTY;
                rsp_data_q   <= fqvp_pkg::EmptyWord;
              end
            end else if (req.op == fqvp_pkg::OP_PURGE) begin
              // Start the walk; the response follows at its end
              rsp_valid_q <= 1'b0;
              val_q       <= req.value;
              steps_q     <= count_q;
              orig_q      <= count_q;
              state_q     <= StWalk;
            end else begin
              // Unused code: report the fill level, change nothing
              rsp_fill_q <= fqvp_pkg::CountW'(count_q);
            end
          end
        end
        StWalk: begin
          if (steps_q != '0) begin
            steps_q <= steps_q - CntW'(1);
            if (!keep) begin
              count_q <= count_m1;
            end
          end else begin
            rsp_status_q  <= fqvp_pkg::ST_OK;
            rsp_data_q    <= '0;
            rsp_removed_q <= fqvp_pkg::CountW'(orig_q - count_q);
            rsp_fill_q    <= fqvp_pkg::CountW'(count_q);
            rsp_valid_q   <= 1'b1;
            state_q       <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign rsp.valid   = rsp_valid_q;
  assign rsp.status  = rsp_status_q;
  assign rsp.data    = rsp_data_q;
  assign rsp.removed = rsp_removed_q;
  assign rsp.fill    = rsp_fill_q;

  // Fill level never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("fill level above capacity");

  // No request is taken during a purge walk
  a_walk_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWalk |-> !req.ready)
    else $error("request taken during purge walk");

  // Remaining walk steps never exceed the entries held
  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWalk |-> steps_q <= count_q && count_q <= orig_q)
    else $error("purge walk counters inconsistent");

  // An accepted enqueue into a queue with room grows it by one
  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && req.op == fqvp_pkg::OP_ENQ && count_q < DepthCnt
    |=> count_q == $past(count_q) + CntW'(1))
    else $error("enqueue did not grow the queue");

  // The response register is not overwritten while still pending
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> !rsp_valid_q || rsp.ready)
    else $error("response overwritten while pending");

endmodule
